### hdl/mfas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfas_pkg;

  // Alignment keeps this many bits below the result lsb; no sticky bit.
  localparam int unsigned GUARD_BITS = 3;

  // Codes of the action field.
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_SUB = 1'b1;

endpackage

`default_nettype wire

### hdl/minifloat_add_sub_unit.sv
// Minifloat adder/subtractor: sign, EXP_BITS exponent, FRAC_BITS fraction.
// Input channel: in_valid/in_stall carry a beat with operands a and b and
// the action code (add or subtract). Output channel: out_valid/out_stall
// carry one result float per input beat, in order.
// A beat is taken at a rising edge with valid high and stall low.
// An accepted beat passes the input register and then the result register;
// the two hold one pass of alignment, add, normalize and round-to-nearest-even
// between them.
// Throughput: one beat per cycle while the output is not stalled.
// When out_stall holds, the result register keeps its beat and the input
// register keeps filling; in_stall rises only once both are occupied.
// Reset (rst, synchronous) empties both registers and drops any beat in them;
// it produces no beat. NaN results are exponent all ones, fraction all ones;
// infinity and overflow give exponent all ones, fraction zero.
`timescale 1ns / 1ps
`default_nettype none

module minifloat_add_sub_unit
  import mfas_pkg::*;
#(
  parameter int unsigned EXP_BITS  = 4,
  parameter int unsigned FRAC_BITS = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 sign_a,
  input  wire logic [EXP_BITS-1:0]  exp_a,
  input  wire logic [FRAC_BITS-1:0] frac_a,
  input  wire logic                 sign_b,
  input  wire logic [EXP_BITS-1:0]  exp_b,
  input  wire logic [FRAC_BITS-1:0] frac_b,
  input  wire logic                 action,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      sign_out,
  output logic [EXP_BITS-1:0]       exp_out,
  output logic [FRAC_BITS-1:0]      frac_out
);

  localparam int unsigned MW  = FRAC_BITS + 1;              // mantissa with hidden bit
  localparam int unsigned RW  = MW + GUARD_BITS + 1;        // sum width with carry
  localparam int unsigned EW  = EXP_BITS + 1;               // exponent with overflow
  localparam int unsigned LZW = $clog2(MW + 1);

  localparam logic [EXP_BITS-1:0]  EMAX  = '1;
  localparam logic [FRAC_BITS-1:0] FMASK = '1;

  // input register
  logic                 s1_valid;
  logic                 a_sign, b_sign, act;
  logic [EXP_BITS-1:0]  a_exp, b_exp;
  logic [FRAC_BITS-1:0] a_frac, b_frac;

  logic out_free;
  logic s1_load;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign s1_load  = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
    if (s1_load && in_valid) begin
      a_sign <= sign_a;
      a_exp  <= exp_a;
      a_frac <= frac_a;
      b_sign <= sign_b;
      b_exp  <= exp_b;
      b_frac <= frac_b;
      act    <= action;
    end
  end

  // datapath
  logic                 swap, sub, true_sub, is_nan, is_inf;
  logic                 big_sign, small_sign, res_sign;
  logic [EXP_BITS-1:0]  big_exp, small_exp, sh;
  logic [FRAC_BITS-1:0] big_frac, small_frac;
  logic [MW-1:0]        big_mant, small_mant;
  logic [RW-1:0]        l_al, s_al, r_sum, r_norm;
  logic [EW-1:0]        e_norm, re;
  logic [LZW-1:0]       lz;
  logic                 carry;
  logic [MW:0]          rr;
  logic [EXP_BITS-1:0]  res_exp;
  logic [FRAC_BITS-1:0] res_frac;

  always_comb begin
    swap = (b_exp > a_exp) || (b_exp == a_exp && b_frac > a_frac);
    sub  = (act == ACT_SUB);

    big_sign   = swap ? b_sign : a_sign;
    big_exp    = swap ? b_exp  : a_exp;
    big_frac   = swap ? b_frac : a_frac;
    small_sign = swap ? a_sign : b_sign;
    small_exp  = swap ? a_exp  : b_exp;
    small_frac = swap ? a_frac : b_frac;
    res_sign   = swap ? (sub ^ b_sign) : a_sign;

    true_sub = sub ^ (big_sign != small_sign);
    is_nan   = (big_exp == EMAX && big_frac != '0) ||
               (small_exp == EMAX && small_frac != '0) ||
               (true_sub && big_exp == EMAX && small_exp == EMAX);
    is_inf   = (big_exp == EMAX) || (small_exp == EMAX);

    big_mant   = {big_exp != '0, big_frac};
    small_mant = {small_exp != '0, small_frac};
    // a denormal operand sits at exponent 1
    sh   = big_exp - small_exp -
           EXP_BITS'((big_exp != '0 && small_exp == '0) ? 1 : 0);
    l_al = RW'(big_mant) << GUARD_BITS;
    s_al = (RW'(small_mant) << GUARD_BITS) >> sh;
    r_sum = true_sub ? (l_al - s_al) : (l_al + s_al);

    // leading zeros of the integer part; guard-only values count all MW
    lz = LZW'(MW);
    for (int i = 0; i < MW; i++) begin
      if (r_sum[GUARD_BITS + i]) lz = LZW'(MW - 1 - i);
    end

    r_norm = r_sum;
    e_norm = EW'(big_exp);
    if (r_sum[GUARD_BITS + MW]) begin
      r_norm = r_sum >> 1;
      e_norm = e_norm + EW'(1);
    end else if (r_sum[GUARD_BITS + FRAC_BITS]) begin
      if (big_exp == '0) e_norm = EW'(1);
    end else if (r_sum == '0) begin
      e_norm = '0;
    end else if (int'(e_norm) > int'(lz)) begin
      r_norm = r_sum << lz;
      e_norm = e_norm - EW'(lz);
    end else begin
      if (e_norm != '0) r_norm = r_sum << (e_norm - EW'(1));
      e_norm = '0;
    end

    // round to nearest even on the guard bits
    carry = r_norm[GUARD_BITS-1] &&
            (r_norm[GUARD_BITS-2] || r_norm[GUARD_BITS-3] || r_norm[GUARD_BITS]);
    rr = {1'b0, r_norm[GUARD_BITS + FRAC_BITS : GUARD_BITS]} + (MW + 1)'(carry);
    re = e_norm;
    if (rr[MW]) begin
      re = re + EW'(1);
    end else if (re == '0 && rr[FRAC_BITS]) begin
      re = EW'(1);
    end

    if (re >= EW'(EMAX)) begin
      res_exp  = EMAX;
      res_frac = '0;
    end else begin
      res_exp  = re[EXP_BITS-1:0];
      res_frac = rr[FRAC_BITS-1:0];
    end
    if (is_nan) begin
      res_exp  = EMAX;
      res_frac = FMASK;
    end else if (is_inf) begin
      res_exp  = EMAX;
      res_frac = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (out_free && s1_valid) begin
      sign_out <= res_sign;
      exp_out  <= res_exp;
      frac_out <= res_frac;
    end
  end

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free slot");

  a_hold_s1 : assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && out_valid)
    else $error("beat dropped under output stall");

  a_take_beat : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted beat not in input register");

  a_special_code : assert property (@(posedge clk) disable iff (rst)
    out_valid && exp_out == EMAX |-> frac_out == '0 || frac_out == FMASK)
    else $error("bad infinity or NaN encoding");

endmodule

`default_nettype wire
